FILE: src/fpr_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update of the framed packet receiver.
package fpr_pkg;

   localparam logic [7:0]  SYNC_BYTE        = 8'h40;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;
   localparam logic [15:0] OVERHEAD_LEN     = 16'd7;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
   localparam logic [15:0] MAX_TOTAL_RESET  = 16'd73;
   localparam int          CSR_INDEX_WIDTH  = 8;
   localparam int          RSP_DATA_WIDTH   = 56;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIMEOUT_TICKS    = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_TOTAL_LENGTH = 8'd1;

   localparam logic       ACTION_BYTE = 1'b0;
   localparam logic       ACTION_TICK = 1'b1;
   localparam logic       KIND_PAYLOAD = 1'b0;
   localparam logic       KIND_VERDICT = 1'b1;
   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_BAD     = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [15:0] payload_index;
      logic [1:0] status;
      logic [7:0] queue_id;
      logic [15:0] payload_length;
      logic       last;
   } result_type;

   typedef struct packed {
      logic                       write;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [15:0]                data;
   } csr_write_type;

   // One byte through the reflected CRC: eight shift-and-xor steps on 16 bits.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: src/framed_packet_receiver_crc16_core.sv
// Top level of the framed packet receiver with CRC-16/MODBUS check.
//
// The receiver takes one transaction per cycle on the req_ stream: either a received serial
// byte or a one millisecond tick. Each transaction is captured in an input register. The
// parser consumes it in the first cycle in which the output register can take a result
// (empty, or being drained by rsp_tready). It does so with a single pass of logic (state
// update plus one table-free CRC byte update) and writes at most one result into the output
// register. Throughput is one transaction per clock as long as the rsp_ side takes results. Each
// transaction passes through the input register and the parser, and its result is registered
// in the output register before it shows on rsp_. While a result waits for rsp_tready, the
// input register still takes one more transaction. After that, req_tready stays low until
// the result is taken, also for transactions that yield no result. Payload bytes are passed
// through as they arrive, each tagged with its index, and an end-of-packet verdict (good
// CRC, bad CRC or timeout abort) closes each packet with rsp_tlast high. Configuration
// writes on the csr_ port are always accepted and should be made while the block is
// idle.
module framed_packet_receiver_crc16_core (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] data_byte
   input  logic                                req_tuser,  // [0] action (0 byte, 1 tick)
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] payload_byte, [23:8] payload_index, [25:24] status, [33:26] queue_id,
   // [49:34] payload_length, [55:50] zero
   output logic [fpr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                rsp_tuser,  // [0] kind (0 payload, 1 verdict)
   output logic                                rsp_tlast,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                         csr_data
);

   fpr_pkg::item_type      req_item;
   fpr_pkg::item_type      item;
   fpr_pkg::result_type    result;
   fpr_pkg::result_type    rsp_result;
   fpr_pkg::csr_write_type csr;
   logic                   step;
   logic                   res_valid;
   logic                   out_can_take;

   assign req_item.action    = req_tuser;
   assign req_item.data_byte = req_tdata;

   // Register writes never stall.
   assign csr_ready = 1'b1;
   assign csr.write = csr_valid && csr_ready;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   fpr_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_item     (req_item),
      .out_can_take (out_can_take),
      .step         (step),
      .item         (item)
   );

   fpr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .result    (result)
   );

   fpr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (step && res_valid),
      .result     (result),
      .can_take   (out_can_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   // Pack the result fields, lowest field in the lowest bits.
   assign rsp_tdata = {6'd0,
                       rsp_result.payload_length,
                       rsp_result.queue_id,
                       rsp_result.status,
                       rsp_result.payload_index,
                       rsp_result.payload_byte};
   assign rsp_tuser = rsp_result.kind;
   assign rsp_tlast = rsp_result.last;

endmodule

FILE: src/fpr_in_stage.sv
// Input register of the framed packet receiver: holds one accepted transaction.
module fpr_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  fpr_pkg::item_type req_item,
   input  logic              out_can_take,
   output logic              step,
   output fpr_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   fpr_pkg::item_type item_ff;

   // The held item moves on whenever the result register has room.
   assign step       = valid_ff && out_can_take;
   assign req_tready = !valid_ff || step;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

endmodule

FILE: src/fpr_parser.sv
// Frame parser: preamble hunt, header, payload pass-through, CRC check and inactivity timeout.
module fpr_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  fpr_pkg::csr_write_type csr,
   input  logic                   step,
   input  fpr_pkg::item_type      item,
   output logic                   res_valid,
   output fpr_pkg::result_type    result
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PREAMBLE,
      PH_HEADER,
      PH_DATA,
      PH_CRC
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hdr_count_ff, hdr_count_in;
   logic [15:0] frame_len_ff, frame_len_in;
   logic [7:0]  queue_ff, queue_in;
   logic [15:0] pay_count_ff, pay_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] countdown_ff, countdown_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [15:0] max_len_ff, max_len_in;

   logic [15:0] crc_next;
   logic [15:0] new_len;
   logic [15:0] count_dec;
   logic        clear;

   assign crc_next  = fpr_pkg::crc_feed(crc_ff, item.data_byte);
   assign new_len   = {item.data_byte, frame_len_ff[7:0]};
   assign count_dec = (countdown_ff != 16'd0) ? (countdown_ff - 16'd1) : 16'd0;

   always_comb begin
      timeout_in = timeout_ff;
      max_len_in = max_len_ff;
      if (csr.write) begin
         unique case (csr.index)
            fpr_pkg::REG_TIMEOUT_TICKS:    timeout_in = csr.data;
            fpr_pkg::REG_MAX_TOTAL_LENGTH: max_len_in = csr.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      frame_len_in = frame_len_ff;
      queue_in     = queue_ff;
      pay_count_in = pay_count_ff;
      crc_in       = crc_ff;
      crc_low_in   = crc_low_ff;
      countdown_in = countdown_ff;
      clear        = 1'b0;
      res_valid    = 1'b0;

      result.kind           = fpr_pkg::KIND_PAYLOAD;
      result.payload_byte   = 8'd0;
      result.payload_index  = 16'd0;
      result.status         = fpr_pkg::STATUS_GOOD;
      result.queue_id       = queue_ff;
      result.payload_length = frame_len_ff - fpr_pkg::OVERHEAD_LEN;
      result.last           = 1'b0;

      if (step) begin
         if (item.action == fpr_pkg::ACTION_TICK) begin
            countdown_in = count_dec;
            if (count_dec == 16'd0) begin
               if (phase_ff == PH_DATA || phase_ff == PH_CRC) begin
                  res_valid     = 1'b1;
                  result.kind   = fpr_pkg::KIND_VERDICT;
                  result.status = fpr_pkg::STATUS_TIMEOUT;
                  result.last   = 1'b1;
               end
               clear = 1'b1;
            end
         end else begin
            countdown_in = timeout_ff;
            unique case (phase_ff)
               PH_IDLE: begin
                  if (item.data_byte == fpr_pkg::SYNC_BYTE) begin
                     clear = 1'b1;
                  end
               end
               PH_PREAMBLE: begin
                  if (item.data_byte == fpr_pkg::SYNC_BYTE) begin
                     crc_in       = crc_next;
                     phase_in     = PH_HEADER;
                     hdr_count_in = 2'd0;
                  end else begin
                     clear = 1'b1;
                  end
               end
               PH_HEADER: begin
                  crc_in = crc_next;
                  if (hdr_count_ff == 2'd0) begin
                     frame_len_in = {8'd0, item.data_byte};
                     hdr_count_in = 2'd1;
                  end else if (hdr_count_ff == 2'd1) begin
                     frame_len_in = new_len;
                     if (new_len < fpr_pkg::OVERHEAD_LEN || new_len > max_len_ff) begin
                        clear = 1'b1;
                     end else begin
                        hdr_count_in = 2'd2;
                     end
                  end else begin
                     queue_in     = item.data_byte;
                     pay_count_in = 16'd0;
                     phase_in     = PH_DATA;
                  end
               end
               PH_DATA: begin
                  if (pay_count_ff < frame_len_ff - fpr_pkg::OVERHEAD_LEN) begin
                     crc_in               = crc_next;
                     res_valid            = 1'b1;
                     result.payload_byte  = item.data_byte;
                     result.payload_index = pay_count_ff;
                     pay_count_in         = pay_count_ff + 16'd1;
                  end else begin
                     crc_low_in = item.data_byte;
                     phase_in   = PH_CRC;
                  end
               end
               PH_CRC: begin
                  res_valid     = 1'b1;
                  result.kind   = fpr_pkg::KIND_VERDICT;
                  result.last   = 1'b1;
                  result.status = ({item.data_byte, crc_low_ff} == crc_ff) ?
                                  fpr_pkg::STATUS_GOOD : fpr_pkg::STATUS_BAD;
                  clear         = 1'b1;
               end
               default: clear = 1'b1;
            endcase
         end
      end

      if (clear) begin
         phase_in     = PH_IDLE;
         hdr_count_in = 2'd0;
         frame_len_in = 16'd0;
         queue_in     = 8'd0;
         pay_count_in = 16'd0;
         crc_in       = fpr_pkg::CRC_INIT;
         crc_low_in   = 8'd0;
         // A sync byte in idle opens a new frame after the clear.
         if (step && item.action == fpr_pkg::ACTION_BYTE && phase_ff == PH_IDLE) begin
            crc_in   = fpr_pkg::crc_feed(fpr_pkg::CRC_INIT, item.data_byte);
            phase_in = PH_PREAMBLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hdr_count_ff <= 2'd0;
         frame_len_ff <= 16'd0;
         queue_ff     <= 8'd0;
         pay_count_ff <= 16'd0;
         crc_ff       <= fpr_pkg::CRC_INIT;
         crc_low_ff   <= 8'd0;
         countdown_ff <= 16'd0;
         timeout_ff   <= fpr_pkg::TIMEOUT_RESET;
         max_len_ff   <= fpr_pkg::MAX_TOTAL_RESET;
      end else begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         frame_len_ff <= frame_len_in;
         queue_ff     <= queue_in;
         pay_count_ff <= pay_count_in;
         crc_ff       <= crc_in;
         crc_low_ff   <= crc_low_in;
         countdown_ff <= countdown_in;
         timeout_ff   <= timeout_in;
         max_len_ff   <= max_len_in;
      end
   end

endmodule

FILE: src/fpr_out_stage.sv
// Result register of the framed packet receiver: holds one result until the sink takes it.
module fpr_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  fpr_pkg::result_type result,
   output logic                can_take,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output fpr_pkg::result_type rsp_result
);

   logic                valid_ff;
   logic                valid_in;
   fpr_pkg::result_type result_ff;

   assign can_take   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

FILE: test/deframer_check_pkg.sv
// Scoreboard for the framed packet receiver: frame parser prediction and result comparison.
package deframer_check_pkg;

   import fpr_pkg::*;

   typedef enum logic [2:0] {
      HUNT,
      SECOND_SYNC,
      HEADER,
      PAYLOAD,
      CRC_TAIL
   } parse_phase_e;

   class deframer_checker;
      logic [15:0]  timeout_reload;
      logic [15:0]  max_total;
      parse_phase_e phase;
      logic [1:0]   hdr_count;
      logic [15:0]  frame_len;
      logic [7:0]   frame_queue;
      logic [15:0]  pay_count;
      logic [15:0]  crc_acc;
      logic [7:0]   crc_low;
      logic [15:0]  countdown;
      result_type   due_results[$];
      int unsigned  failures = 0;
      int unsigned  items = 0;
      int unsigned  payload_seen = 0;
      int unsigned  good_seen = 0;
      int unsigned  bad_seen = 0;
      int unsigned  aborts_seen = 0;

      function new();
         timeout_reload = TIMEOUT_RESET;
         max_total      = MAX_TOTAL_RESET;
         countdown      = 16'd0;
         restart_parser();
      endfunction

      // Bit-serial CRC-16/MODBUS, data taken LSB first.
      static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
               c = c ^ CRC_POLY;
            end
         end
         return c;
      endfunction

      function void restart_parser();
         phase       = HUNT;
         hdr_count   = 2'd0;
         frame_len   = 16'd0;
         frame_queue = 8'd0;
         pay_count   = 16'd0;
         crc_acc     = CRC_INIT;
         crc_low     = 8'd0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] val);
         if (idx == REG_TIMEOUT_TICKS) begin
            timeout_reload = val;
         end else if (idx == REG_MAX_TOTAL_LENGTH) begin
            max_total = val;
         end
      endfunction

      function result_type frame_result(logic kind, logic [7:0] b, logic [15:0] idx,
                                        logic [1:0] st);
         result_type r;
         r.kind           = kind;
         r.payload_byte   = b;
         r.payload_index  = idx;
         r.status         = st;
         r.queue_id       = frame_queue;
         r.payload_length = frame_len - OVERHEAD_LEN;
         r.last           = kind;
         return r;
      endfunction

      // Advances the parser by one accepted transaction and queues what it produces.
      function void note_item(item_type it);
         logic [1:0] verdict;
         items++;
         if (it.action == ACTION_TICK) begin
            if (countdown != 16'd0) begin
               countdown--;
            end
            if (countdown == 16'd0) begin
               // Only a packet whose header is complete gets a timeout verdict.
               if (phase == PAYLOAD || phase == CRC_TAIL) begin
                  due_results.push_back(frame_result(KIND_VERDICT, 8'h00, 16'h0000,
                                                     STATUS_TIMEOUT));
               end
               restart_parser();
            end
         end else begin
            countdown = timeout_reload;
            case (phase)
               HUNT: begin
                  if (it.data_byte == SYNC_BYTE) begin
                     restart_parser();
                     crc_acc = crc_step(CRC_INIT, it.data_byte);
                     phase   = SECOND_SYNC;
                  end
               end
               SECOND_SYNC: begin
                  if (it.data_byte == SYNC_BYTE) begin
                     crc_acc   = crc_step(crc_acc, it.data_byte);
                     phase     = HEADER;
                     hdr_count = 2'd0;
                  end else begin
                     restart_parser();
                  end
               end
               HEADER: begin
                  crc_acc = crc_step(crc_acc, it.data_byte);
                  case (hdr_count)
                     2'd0: begin
                        frame_len = {8'h00, it.data_byte};
                        hdr_count = 2'd1;
                     end
                     2'd1: begin
                        frame_len[15:8] = it.data_byte;
                        if (frame_len < OVERHEAD_LEN || frame_len > max_total) begin
                           restart_parser();
                        end else begin
                           hdr_count = 2'd2;
                        end
                     end
                     default: begin
                        frame_queue = it.data_byte;
                        pay_count   = 16'd0;
                        phase       = PAYLOAD;
                     end
                  endcase
               end
               PAYLOAD: begin
                  if (pay_count < frame_len - OVERHEAD_LEN) begin
                     crc_acc = crc_step(crc_acc, it.data_byte);
                     // Payload results carry a zero status.
                     due_results.push_back(frame_result(KIND_PAYLOAD, it.data_byte, pay_count,
                                                        STATUS_GOOD));
                     pay_count++;
                  end else begin
                     crc_low = it.data_byte;
                     phase   = CRC_TAIL;
                  end
               end
               CRC_TAIL: begin
                  verdict = ({it.data_byte, crc_low} == crc_acc) ? STATUS_GOOD : STATUS_BAD;
                  due_results.push_back(frame_result(KIND_VERDICT, 8'h00, 16'h0000, verdict));
                  restart_parser();
               end
               default: begin
                  restart_parser();
               end
            endcase
         end
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            failures++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (due_results.size() == 0) begin
            failures++;
            $error("result with nothing pending: kind %0d, byte 0x%0h, status %0d",
                   got.kind, got.payload_byte, got.status);
            return;
         end
         want = due_results.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("payload_index", want.payload_index, got.payload_index);
         compare_field("status", want.status, got.status);
         compare_field("queue_id", want.queue_id, got.queue_id);
         compare_field("payload_length", want.payload_length, got.payload_length);
         compare_field("last", want.last, got.last);
         if (want.kind == KIND_PAYLOAD) begin
            payload_seen++;
         end else begin
            case (want.status)
               STATUS_GOOD: good_seen++;
               STATUS_BAD:  bad_seen++;
               default:     aborts_seen++;
            endcase
         end
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction
   endclass

endpackage

FILE: test/tb_framed_packet_receiver_crc16_core.sv
// Testbench top for the framed packet receiver: directed frames, random serial traffic and ticks.
module tb_framed_packet_receiver_crc16_core;

   timeunit 1ns;
   timeprecision 1ps;

   import fpr_pkg::*;
   import deframer_check_pkg::*;

   // A byte that yields nothing may still be in the input register when the last expected
   // result shows up, so settle() keeps draining after the last result.
   localparam int DRAIN_CYCLES = 8;
   // Cycles without any transaction on any channel before the run is declared hung.
   localparam int STALL_LIMIT  = 2000;

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = 8'h00;
   logic                       req_tuser  = ACTION_BYTE;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = REG_TIMEOUT_TICKS;
   logic [15:0]                csr_data   = 16'h0000;

   deframer_checker chk;
   item_type        stim_q[$];
   int              sender_idle_pct = 17;
   int              rsp_stall_pct   = 84;
   int              tick_pct        = 0;
   int              tick_burst      = 1;
   int unsigned     quiet_cycles    = 0;
   int unsigned     settings_used   = 1;

   framed_packet_receiver_crc16_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side stalls at random; the level is changed between phases of the run.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every result transaction is unpacked from tdata/tuser/tlast and handed to the scoreboard.
   always @(posedge clock) begin : rsp_monitor
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind           = rsp_tuser;
         got.payload_byte   = rsp_tdata[7:0];
         got.payload_index  = rsp_tdata[23:8];
         got.status         = rsp_tdata[25:24];
         got.queue_id       = rsp_tdata[33:26];
         got.payload_length = rsp_tdata[49:34];
         got.last           = rsp_tlast;
         chk.check_result(got);
      end
   end

   // Hang detection: any accepted transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("no transaction for %0d cycles, %0d results still pending",
                  STALL_LIMIT, chk.pending());
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // A byte that cannot start a frame, so noise never opens a packet by accident.
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == SYNC_BYTE) begin
         b = ~b;
      end
      return b;
   endfunction

   function automatic void push_ticks(input int n);
      item_type it;
      it.action = ACTION_TICK;
      repeat (n) begin
         // The byte lane is don't-care on a tick, so it carries random bits.
         it.data_byte = 8'($urandom);
         stim_q.push_back(it);
      end
   endfunction

   // Queues one serial byte, sometimes preceded by a burst of millisecond ticks.
   function automatic void push_byte(input logic [7:0] b);
      item_type it;
      if ($urandom_range(99) < tick_pct) begin
         push_ticks($urandom_range(1, tick_burst));
      end
      it.action    = ACTION_BYTE;
      it.data_byte = b;
      stim_q.push_back(it);
   endfunction

   // Queues a frame with the given total length. A length the parser will reject yields only
   // the preamble and length bytes. fill < 0 means random payload, keep < 0 the whole frame.
   function automatic void add_frame(input logic [15:0] total, input logic [7:0] queue,
                                     input bit bad_crc, input int fill, input int keep);
      logic [7:0]  bytes[$];
      logic [15:0] crc;
      bytes = {SYNC_BYTE, SYNC_BYTE, total[7:0], total[15:8]};
      if (total >= OVERHEAD_LEN && total <= chk.max_total) begin
         bytes.push_back(queue);
         for (int i = 0; i < int'(total) - 7; i++) begin
            bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
         end
         crc = CRC_INIT;
         foreach (bytes[i]) begin
            crc = deframer_checker::crc_step(crc, bytes[i]);
         end
         if (bad_crc) begin
            crc ^= 16'($urandom_range(1, 65535));
         end
         bytes.push_back(crc[7:0]);
         bytes.push_back(crc[15:8]);
      end
      if (keep < 0 || keep > bytes.size()) begin
         keep = bytes.size();
      end
      for (int i = 0; i < keep; i++) begin
         push_byte(bytes[i]);
      end
   endfunction

   // Mostly short frames, now and then one of exactly the largest accepted length.
   function automatic logic [15:0] frame_total();
      int hi;
      hi = (chk.max_total < 16'd30) ? int'(chk.max_total) : 30;
      if (hi < 7) begin
         return 16'($urandom_range(7, 30));
      end
      if ($urandom_range(9) == 0 && chk.max_total <= 16'd100) begin
         return chk.max_total;
      end
      return 16'($urandom_range(7, hi));
   endfunction

   // Random traffic: mostly well-formed frames with random content; the rest is rejected
   // lengths, broken preambles, line noise and, where allowed, frames cut off and then
   // flushed by enough ticks to run the inactivity timer down.
   function automatic void build_traffic(input int target, input bit cuts);
      int          pick;
      logic [15:0] total;
      while (stim_q.size() < target) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            if (chk.max_total < 16'hFFFF && $urandom_range(1) == 1) begin
               total = ($urandom_range(1) == 1) ? chk.max_total + 16'd1
                     : 16'($urandom_range(int'(chk.max_total) + 1, 65535));
            end else begin
               total = 16'($urandom_range(0, 6));
            end
            add_frame(total, 8'($urandom), 1'b0, -1, -1);
         end else if (pick < 14) begin
            push_byte(SYNC_BYTE);
            push_byte(noise_byte());
         end else if (pick < 22) begin
            repeat ($urandom_range(1, 4)) push_byte(noise_byte());
         end else if (pick < 30 && cuts) begin
            total = frame_total();
            add_frame(total, 8'($urandom), 1'b0, -1, $urandom_range(1, int'(total) - 1));
            push_ticks(int'(chk.timeout_reload) + 1);
         end else begin
            add_frame(frame_total(), 8'($urandom), ($urandom_range(7) == 0), -1, -1);
         end
      end
   endfunction

   // Presents one transaction on the input stream and waits for it to be taken.
   task automatic send_item(input item_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.data_byte;
      req_tuser  <= it.action;
      do @(posedge clock); while (!req_tready);
      chk.note_item(it);
      @(negedge clock);
   endtask

   task automatic play_traffic();
      while (stim_q.size() > 0) begin
         send_item(stim_q.pop_front());
      end
      req_tvalid <= 1'b0;
   endtask

   // Waits until every predicted result has been seen and the pipeline has emptied.
   task automatic settle();
      while (chk.pending() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Leaves csr_valid high so that back-to-back writes need no extra assignment.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      chk.write_reg(idx, val);
      @(negedge clock);
   endtask

   // Both registers, then a write to an unused index that the block must ignore.
   task automatic set_config(input logic [15:0] ticks, input logic [15:0] max_len);
      write_reg(REG_TIMEOUT_TICKS, ticks);
      write_reg(REG_MAX_TOTAL_LENGTH, max_len);
      write_reg(CSR_INDEX_WIDTH'($urandom_range(int'(REG_MAX_TOTAL_LENGTH) + 1, 255)),
                16'($urandom));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_segment(input logic [15:0] ticks, input logic [15:0] max_len,
                              input int send_idle, input int rsp_stall, input int tick_rate,
                              input int target, input bit cuts, input int big_payload);
      settle();
      set_config(ticks, max_len);
      sender_idle_pct = send_idle;
      rsp_stall_pct   = rsp_stall;
      tick_pct        = tick_rate;
      // Small timeouts get bursts long enough to expire now and then.
      tick_burst      = (ticks <= 16'd20) ? int'(ticks) + 2 : 4;
      if (big_payload > 0) begin
         add_frame(16'(big_payload + 7), 8'($urandom), 1'b0, -1, -1);
      end
      build_traffic(target, cuts);
      play_traffic();
   endtask

   initial begin
      chk = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values: a one-byte payload with every bit
      // set and queue 0xFF, an empty payload with a corrupted CRC and queue 0x00, a second
      // preamble byte that is wrong, and a length one above the default maximum.
      add_frame(16'd8, 8'hFF, 1'b0, 8'hFF, -1);
      add_frame(16'd7, 8'h00, 1'b1, -1, -1);
      push_byte(SYNC_BYTE);
      push_byte(8'h41);
      add_frame(MAX_TOTAL_RESET + 16'd1, 8'h11, 1'b0, -1, -1);
      play_traffic();

      // A zero timeout: the very next tick aborts a packet that is waiting for its CRC.
      settle();
      set_config(16'd0, 16'd7);
      add_frame(16'd7, 8'hA5, 1'b0, -1, 6);
      push_ticks(1);
      play_traffic();

      // Random phases: sender mostly busy and receiver mostly stalled, then the reverse,
      // then full rate on both sides, across small, zero and extreme register values.
      run_segment(16'd3, 16'd73, 17, 84, 6, 450, 1'b1, 0);
      run_segment(16'hFFFF, 16'hFFFF, 84, 17, 6, 450, 1'b0, 300);
      run_segment(16'd0, 16'd7, 0, 0, 3, 150, 1'b1, 0);
      run_segment(16'd1, 16'd6, 0, 0, 5, 60, 1'b1, 0);
      run_segment(16'd20, 16'd40, 0, 0, 5, 400, 1'b1, 0);

      settle();
      $display("%0d input transactions under %0d register settings; %0d payload bytes checked",
               chk.items, settings_used, chk.payload_seen);
      $display("verdicts checked: %0d good CRC, %0d bad CRC, %0d timeout aborts; %0d mismatches",
               chk.good_seen, chk.bad_seen, chk.aborts_seen, chk.failures);
      if (chk.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/fpr_pkg.sv
src/fpr_in_stage.sv
src/fpr_parser.sv
src/fpr_out_stage.sv
src/framed_packet_receiver_crc16_core.sv
test/deframer_check_pkg.sv
test/tb_framed_packet_receiver_crc16_core.sv
